// ===== design/tve_pkg.sv =====
// Package for the target velocity estimator.
// Holds widths, register indexes, divider phase codes and the controller/datapath structs.
// No dependencies.
`default_nettype none

package tve_pkg;

  localparam int TIDX_W      = 4;
  localparam int MAX_TARGETS = 1 << TIDX_W;
  localparam int CNT_W       = TIDX_W + 1;
  localparam int DATA_W      = 32;
  localparam int FRAC_W      = 16;
  localparam int DIFF_W      = DATA_W + 1;
  localparam int CFG_IDX_W   = 1;
  localparam int DIV_CNT_W   = 6;

  localparam logic [CFG_IDX_W-1:0] REG_TIME_TOLERANCE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT   = 1'b1;

  localparam logic [DATA_W-1:0] TOL_RESET = DATA_W'(1);
  localparam logic [DATA_W-1:0] SAT_POS   = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_NEG   = {1'b1, {(DATA_W-1){1'b0}}};

  localparam logic [DIV_CNT_W-1:0] DIV_PH_ABS  = DIV_CNT_W'(0);
  localparam logic [DIV_CNT_W-1:0] DIV_PH_INIT = DIV_CNT_W'(1);
  localparam logic [DIV_CNT_W-1:0] DIV_PH_DONE = DIV_CNT_W'(DATA_W + 2);

  typedef struct packed {
    logic capture;
    logic update;
    logic calc;
    logic div_start;
    logic store_speed;
    logic load_out;
  } tve_cmd_t;

  typedef struct packed {
    logic fresh;
    logic div_done;
  } tve_status_t;

endpackage

`default_nettype wire

// ===== design/tve_div.sv =====
// Iterative restoring divider: saturated signed (num * 2^16) / den, one quotient bit a cycle.
// Depends on tve_pkg.
`default_nettype none

module tve_div import tve_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] num,
  input  logic signed [DIFF_W-1:0] den,
  output logic                     done,
  output logic [DATA_W-1:0]        quot
);

  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 neg_r;
  logic                 ovf_r;
  logic [DIFF_W-1:0]    num_r;
  logic [DIFF_W-1:0]    den_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    q_r;
  logic [DATA_W-1:0]    hi_ext;
  logic [DIFF_W:0]      trial;

  assign hi_ext = {{(DATA_W-(DIFF_W-FRAC_W)){1'b0}}, num_r[DIFF_W-1:FRAC_W]};
  assign trial  = {1'b0, rem_r, q_r[DATA_W-1]} - {2'b00, den_r[DATA_W-1:0]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= DIV_PH_DONE;
    end else if (start) begin
      cnt_r <= DIV_PH_ABS;
    end else if (cnt_r != DIV_PH_DONE) begin
      cnt_r <= cnt_r + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      neg_r <= num[DIFF_W-1] ^ den[DIFF_W-1];
    end else if (cnt_r == DIV_PH_ABS) begin
      num_r <= num_r[DIFF_W-1] ? -num_r : num_r;
      den_r <= den_r[DIFF_W-1] ? -den_r : den_r;
    end else if (cnt_r == DIV_PH_INIT) begin
      ovf_r <= (hi_ext >= den_r[DATA_W-1:0]);
      rem_r <= hi_ext;
      q_r   <= {num_r[FRAC_W-1:0], {(DATA_W-FRAC_W){1'b0}}};
    end else if (cnt_r != DIV_PH_DONE) begin
      if (!trial[DIFF_W]) begin
        rem_r <= trial[DATA_W-1:0];
      end else begin
        rem_r <= {rem_r[DATA_W-2:0], q_r[DATA_W-1]};
      end
      q_r <= {q_r[DATA_W-2:0], ~trial[DIFF_W]};
    end
  end

  assign done = (cnt_r == DIV_PH_DONE);

  always_comb begin
    if (neg_r) begin
      quot = (ovf_r || (q_r[DATA_W-1] && |q_r[DATA_W-2:0])) ? SAT_NEG : -q_r;
    end else begin
      quot = (ovf_r || q_r[DATA_W-1]) ? SAT_POS : q_r;
    end
  end

endmodule

`default_nettype wire

// ===== design/tve_ctrl.sv =====
// Controller state machine of the target velocity estimator.
// Sequences table update, difference calculation, division and result hand-off; depends on tve_pkg.
`default_nettype none

module tve_ctrl import tve_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  output tve_cmd_t    cmd,
  input  tve_status_t st
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_UPDATE = 6'b000010,
    ST_CALC   = 6'b000100,
    ST_LAUNCH = 6'b001000,
    ST_DIVIDE = 6'b010000,
    ST_FINISH = 6'b100000
  } tve_state_t;

  tve_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = ST_LAUNCH;
      end
      ST_LAUNCH: begin
        if (st.fresh) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DIVIDE;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_DIVIDE: begin
        if (st.div_done) begin
          cmd.store_speed = 1'b1;
          state_nxt       = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || !out_stall))
    else $error("result register overwritten before its beat was taken");

  a_divide_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVIDE && st.div_done) |=> (state_r == ST_FINISH))
    else $error("controller did not leave the divide phase on completion");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_UPDATE))
    else $error("accepted beat did not start a table update");

endmodule

`default_nettype wire

// ===== design/tve_datapath.sv =====
// Datapath of the target velocity estimator: configuration, target table, differences,
// two divider lanes and the result register. Depends on tve_pkg and tve_div.
`default_nettype none

module tve_datapath import tve_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata,
  input  logic [TIDX_W-1:0]        in_target_index,
  input  logic signed [DATA_W-1:0] in_pos_x,
  input  logic signed [DATA_W-1:0] in_pos_y,
  input  logic [DATA_W-1:0]        in_sample_time,
  output logic signed [DATA_W-1:0] out_speed_x,
  output logic signed [DATA_W-1:0] out_speed_y,
  output logic                     out_speed_fresh,
  output logic                     out_zero_interval,
  output logic                     out_table_ready,
  input  tve_cmd_t                 cmd,
  output tve_status_t              st
);

  logic [DATA_W-1:0]      tol_r;
  logic [CNT_W-1:0]       tcount_r;

  logic [TIDX_W-1:0]      idx_r;
  logic [DATA_W-1:0]      px_r, py_r, t_r;

  logic [MAX_TARGETS-1:0] cur_valid_r, prev_valid_r;
  logic [CNT_W-1:0]       cur_total_r, prev_total_r;
  logic [DATA_W-1:0]      cur_x_r  [MAX_TARGETS];
  logic [DATA_W-1:0]      cur_y_r  [MAX_TARGETS];
  logic [DATA_W-1:0]      cur_t_r  [MAX_TARGETS];
  logic [DATA_W-1:0]      prev_x_r [MAX_TARGETS];
  logic [DATA_W-1:0]      prev_y_r [MAX_TARGETS];
  logic [DATA_W-1:0]      prev_t_r [MAX_TARGETS];
  logic [DATA_W-1:0]      vel_x_r  [MAX_TARGETS];
  logic [DATA_W-1:0]      vel_y_r  [MAX_TARGETS];

  logic                   fresh_r, zero_r;
  logic signed [DIFF_W-1:0] dx_r, dy_r, dt_r;

  logic [DATA_W-1:0]      spd_x_r, spd_y_r;
  logic                   fresh_o_r, zero_o_r, ready_o_r;

  logic                   cur_v, prev_v, both_v, epoch, dt_zero;
  logic [DATA_W-1:0]      stamp_c, gap;
  logic [DIFF_W-1:0]      gap_up, gap_dn;
  logic [DIFF_W-1:0]      dx_c, dy_c, dt_c;
  logic                   done_x, done_y;
  logic [DATA_W-1:0]      quot_x, quot_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r    <= TOL_RESET;
      tcount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_TOLERANCE: tol_r    <= cfg_wdata;
        REG_TARGET_COUNT:   tcount_r <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_r <= in_target_index;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      t_r   <= in_sample_time;
    end
  end

  assign cur_v   = cur_valid_r[idx_r];
  assign prev_v  = prev_valid_r[idx_r];
  assign stamp_c = cur_t_r[idx_r];
  assign gap_up  = {1'b0, t_r} - {1'b0, stamp_c};
  assign gap_dn  = {1'b0, stamp_c} - {1'b0, t_r};
  assign gap     = gap_up[DATA_W] ? gap_dn[DATA_W-1:0] : gap_up[DATA_W-1:0];
  assign epoch   = (gap > tol_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r  <= '0;
      prev_valid_r <= '0;
      cur_total_r  <= '0;
      prev_total_r <= '0;
    end else if (cmd.update) begin
      if (!cur_v) begin
        cur_valid_r[idx_r] <= 1'b1;
        cur_total_r        <= cur_total_r + CNT_W'(1);
      end else if (epoch && !prev_v) begin
        prev_valid_r[idx_r] <= 1'b1;
        prev_total_r        <= prev_total_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      cur_x_r[idx_r] <= px_r;
      cur_y_r[idx_r] <= py_r;
      cur_t_r[idx_r] <= t_r;
      if (!cur_v) begin
        vel_x_r[idx_r] <= '0;
        vel_y_r[idx_r] <= '0;
      end else if (epoch) begin
        prev_x_r[idx_r] <= cur_x_r[idx_r];
        prev_y_r[idx_r] <= cur_y_r[idx_r];
        prev_t_r[idx_r] <= stamp_c;
      end
    end else if (cmd.store_speed) begin
      vel_x_r[idx_r] <= quot_x;
      vel_y_r[idx_r] <= quot_y;
    end
  end

  assign both_v  = cur_v & prev_v;
  assign dt_zero = (cur_t_r[idx_r] == prev_t_r[idx_r]);
  assign dt_c    = {1'b0, cur_t_r[idx_r]} - {1'b0, prev_t_r[idx_r]};
  assign dx_c    = {cur_x_r[idx_r][DATA_W-1], cur_x_r[idx_r]}
                 - {prev_x_r[idx_r][DATA_W-1], prev_x_r[idx_r]};
  assign dy_c    = {cur_y_r[idx_r][DATA_W-1], cur_y_r[idx_r]}
                 - {prev_y_r[idx_r][DATA_W-1], prev_y_r[idx_r]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fresh_r <= 1'b0;
      zero_r  <= 1'b0;
    end else if (cmd.calc) begin
      fresh_r <= both_v & ~dt_zero;
      zero_r  <= both_v & dt_zero;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      dt_r <= $signed(dt_c);
      dx_r <= $signed(dx_c);
      dy_r <= $signed(dy_c);
    end
  end

  tve_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dx_r),
    .den   (dt_r),
    .done  (done_x),
    .quot  (quot_x)
  );

  tve_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dy_r),
    .den   (dt_r),
    .done  (done_y),
    .quot  (quot_y)
  );

  assign st.fresh    = fresh_r;
  assign st.div_done = done_x & done_y;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      spd_x_r   <= vel_x_r[idx_r];
      spd_y_r   <= vel_y_r[idx_r];
      fresh_o_r <= fresh_r;
      zero_o_r  <= zero_r;
      ready_o_r <= (cur_total_r == tcount_r) && (prev_total_r == tcount_r);
    end
  end

  assign out_speed_x       = $signed(spd_x_r);
  assign out_speed_y       = $signed(spd_y_r);
  assign out_speed_fresh   = fresh_o_r;
  assign out_zero_interval = zero_o_r;
  assign out_table_ready   = ready_o_r;

  a_totals_order: assert property (@(posedge clk) disable iff (!rst_n)
    prev_total_r <= cur_total_r)
    else $error("more previous samples counted than current samples");

  a_update_creates: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |=> cur_valid_r[idx_r])
    else $error("table entry not valid after an update");

  a_store_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.store_speed |-> (fresh_r && !zero_r))
    else $error("speed stored for an item that needed no division");

endmodule

`default_nettype wire

// ===== design/target_velocity_estimator_core.sv =====
// Sequence: an accepted item passes the update, calc and launch states; if its speed is recomputed,
// the two divider lanes run their 32 steps before the finish state loads the result register.
// Other items go from launch straight to finish. The next item is accepted only back in idle.
// One item is worked on at a time; a waiting result does not hold off the next acceptance.
// Reset (rst_n low at a clock edge) clears all valid bits and counts, sets the tolerance to 1
// and the target count to 0; there is no clearing pass. Depends on tve_pkg, tve_ctrl, tve_datapath.
`default_nettype none

module target_velocity_estimator_core import tve_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [TIDX_W-1:0]        in_target_index,
  input  logic signed [DATA_W-1:0] in_pos_x,
  input  logic signed [DATA_W-1:0] in_pos_y,
  input  logic [DATA_W-1:0]        in_sample_time,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [DATA_W-1:0] out_speed_x,
  output logic signed [DATA_W-1:0] out_speed_y,
  output logic                     out_speed_fresh,
  output logic                     out_zero_interval,
  output logic                     out_table_ready,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [DATA_W-1:0]        cfg_wdata
);

  tve_cmd_t    cmd;
  tve_status_t st;

  assign cfg_ready = 1'b1;

  tve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

  tve_datapath u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_valid & cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_target_index   (in_target_index),
    .in_pos_x          (in_pos_x),
    .in_pos_y          (in_pos_y),
    .in_sample_time    (in_sample_time),
    .out_speed_x       (out_speed_x),
    .out_speed_y       (out_speed_y),
    .out_speed_fresh   (out_speed_fresh),
    .out_zero_interval (out_zero_interval),
    .out_table_ready   (out_table_ready),
    .cmd               (cmd),
    .st                (st)
  );

endmodule

`default_nettype wire
